/* hw/rtl/ffca_pkg.sv */
// Shared types, constants and the sequencer control store of the first-fit capacity allocator.
package ffca_pkg;

	// Field widths fixed by the item formats.
	localparam int BIN_W  = 10;
	localparam int VAL_W  = 30;
	localparam int NB_W   = 11;
	localparam int DATA_W = 32;
	localparam int ADDR_W = 2;

	// Default bin count and the reset value of the bin-count register.
	localparam int            FFCA_MAX_BINS     = 1024;
	localparam logic [NB_W-1:0] NUM_BINS_RST    = 11'd1024;
	localparam logic [ADDR_W-1:0] REG_NUM_BINS  = 2'd0;

	// Opcode carried in the func field.
	localparam logic FUNC_LOAD    = 1'b0;
	localparam logic FUNC_REQUEST = 1'b1;

	// Sequencer steps.
	localparam int STEP_W = 3;
	localparam logic [STEP_W-1:0] ST_CLR  = 3'd0;
	localparam logic [STEP_W-1:0] ST_IDLE = 3'd1;
	localparam logic [STEP_W-1:0] ST_DISP = 3'd2;
	localparam logic [STEP_W-1:0] ST_CHK  = 3'd3;
	localparam logic [STEP_W-1:0] ST_DESC = 3'd4;
	localparam logic [STEP_W-1:0] ST_LEAF = 3'd5;
	localparam logic [STEP_W-1:0] ST_UPD  = 3'd6;
	localparam logic [STEP_W-1:0] ST_DONE = 3'd7;

	// Read address selects.
	localparam logic [2:0] RD_ROOT = 3'd0;
	localparam logic [2:0] RD_LEFT = 3'd1;
	localparam logic [2:0] RD_DESC = 3'd2;
	localparam logic [2:0] RD_VSIB = 3'd3;
	localparam logic [2:0] RD_PSIB = 3'd4;

	// Write selects.
	localparam logic [1:0] WR_ZERO = 2'd0;
	localparam logic [1:0] WR_LEAF = 2'd1;
	localparam logic [1:0] WR_PAR  = 2'd2;

	// Node register updates.
	localparam logic [2:0] V_HOLD  = 3'd0;
	localparam logic [2:0] V_INC   = 3'd1;
	localparam logic [2:0] V_START = 3'd2;
	localparam logic [2:0] V_DESC  = 3'd3;
	localparam logic [2:0] V_PAR   = 3'd4;

	// Jump conditions.
	localparam logic [2:0] C_ALWAYS  = 3'd0;
	localparam logic [2:0] C_CLR_END = 3'd1;
	localparam logic [2:0] C_TAKEN   = 3'd2;
	localparam logic [2:0] C_IS_REQ  = 3'd3;
	localparam logic [2:0] C_FIT     = 3'd4;
	localparam logic [2:0] C_LEAF    = 3'd5;
	localparam logic [2:0] C_ROOT    = 3'd6;
	localparam logic [2:0] C_OUT_OK  = 3'd7;

	// Datapath control word.
	typedef struct packed {
		logic       in_rdy;
		logic [2:0] rd_sel;
		logic       wr_en;
		logic [1:0] wr_sel;
		logic [2:0] v_sel;
		logic       found_ld;
		logic       leaf_ld;
		logic       emit;
	} ctl_t;

	// One microinstruction: actions plus a two-way jump.
	typedef struct packed {
		ctl_t              ctl;
		logic [2:0]        cond;
		logic [STEP_W-1:0] tgt;
		logic [STEP_W-1:0] alt;
	} uword_t;

	// Status flags from the datapath to the sequencer.
	typedef struct packed {
		logic clr_end;
		logic ok;
		logic is_req;
		logic fit;
		logic leaf;
		logic root;
	} stat_t;

	// Result fields ready for the output register.
	typedef struct packed {
		logic            found;
		logic [NB_W-1:0] bin_number;
	} res_t;

	// Control store: one word per step.
	function automatic uword_t ffca_urom(input logic [STEP_W-1:0] step);
		uword_t w;
		w = '0;
		unique case (step)
			ST_CLR: begin
				w.ctl.wr_en  = 1'b1;
				w.ctl.wr_sel = WR_ZERO;
				w.ctl.v_sel  = V_INC;
				w.cond       = C_CLR_END;
				w.tgt        = ST_IDLE;
				w.alt        = ST_CLR;
			end
			ST_IDLE: begin
				w.ctl.in_rdy = 1'b1;
				w.cond       = C_TAKEN;
				w.tgt        = ST_DISP;
				w.alt        = ST_IDLE;
			end
			ST_DISP: begin
				w.ctl.rd_sel = RD_ROOT;
				w.ctl.v_sel  = V_START;
				w.cond       = C_IS_REQ;
				w.tgt        = ST_CHK;
				w.alt        = ST_LEAF;
			end
			ST_CHK: begin
				w.ctl.rd_sel   = RD_LEFT;
				w.ctl.found_ld = 1'b1;
				w.cond         = C_FIT;
				w.tgt          = ST_DESC;
				w.alt          = ST_DONE;
			end
			ST_DESC: begin
				w.ctl.rd_sel = RD_DESC;
				w.ctl.v_sel  = V_DESC;
				w.cond       = C_LEAF;
				w.tgt        = ST_LEAF;
				w.alt        = ST_DESC;
			end
			ST_LEAF: begin
				w.ctl.wr_en   = 1'b1;
				w.ctl.wr_sel  = WR_LEAF;
				w.ctl.rd_sel  = RD_VSIB;
				w.ctl.leaf_ld = 1'b1;
				w.cond        = C_ALWAYS;
				w.tgt         = ST_UPD;
				w.alt         = ST_UPD;
			end
			ST_UPD: begin
				w.ctl.wr_en  = 1'b1;
				w.ctl.wr_sel = WR_PAR;
				w.ctl.rd_sel = RD_PSIB;
				w.ctl.v_sel  = V_PAR;
				w.cond       = C_ROOT;
				w.tgt        = ST_DONE;
				w.alt        = ST_UPD;
			end
			ST_DONE: begin
				w.ctl.emit = 1'b1;
				w.cond     = C_OUT_OK;
				w.tgt      = ST_IDLE;
				w.alt      = ST_DONE;
			end
		endcase
		return w;
	endfunction

endpackage

/* hw/rtl/ffca_if.sv */
// Command and response channel interfaces of the first-fit capacity allocator.
interface ffca_cmd_if import ffca_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             func;
	logic [BIN_W-1:0] bin_index;
	logic [VAL_W-1:0] load_value;
	logic [VAL_W-1:0] request_size;

	modport source (output valid, func, bin_index, load_value, request_size, input ready);
	modport sink   (input valid, func, bin_index, load_value, request_size, output ready);
endinterface

interface ffca_rsp_if import ffca_pkg::*; ();
	logic            valid;
	logic            ready;
	logic            found;
	logic [NB_W-1:0] bin_number;

	modport source (output valid, found, bin_number, input ready);
	modport sink   (input valid, found, bin_number, output ready);
endinterface

/* hw/rtl/ffca_useq.sv */
// Microcoded sequencer: step counter, control store lookup and conditional jumps.
module ffca_useq import ffca_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_acc,
	input  logic  out_free,
	input  stat_t st,
	output ctl_t  ctl
);

	logic [STEP_W-1:0] step_q;
	uword_t            uw;
	logic              take;

	// Fetch the control word for the current step.
	assign uw  = ffca_urom(step_q);
	assign ctl = uw.ctl;

	// Evaluate the jump condition of this word.
	always_comb begin
		unique case (uw.cond)
			C_ALWAYS:  take = 1'b1;
			C_CLR_END: take = st.clr_end;
			C_TAKEN:   take = in_acc & st.ok;
			C_IS_REQ:  take = st.is_req;
			C_FIT:     take = st.fit;
			C_LEAF:    take = st.leaf;
			C_ROOT:    take = st.root;
			C_OUT_OK:  take = out_free | ~st.is_req;
		endcase
	end

	// Step counter; reset starts with the clearing sweep.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_CLR;
		end else begin
			step_q <= take ? uw.tgt : uw.alt;
		end
	end

endmodule

/* hw/rtl/ffca_dpath.sv */
// Datapath: max-tree memory, node and value registers, comparator and address selection.
module ffca_dpath import ffca_pkg::*; #(
	parameter int MaxBins = FFCA_MAX_BINS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ctl_t             ctl,
	input  logic             in_acc,
	input  logic             cmd_func,
	input  logic [BIN_W-1:0] cmd_bin,
	input  logic [VAL_W-1:0] cmd_load,
	input  logic [VAL_W-1:0] cmd_req,
	input  logic [NB_W-1:0]  num_bins,
	output stat_t            st,
	output res_t             res
);

	localparam int L     = $clog2(MaxBins);
	localparam int NW    = L + 1;
	localparam int DEPTH = 2 ** NW;

	logic [VAL_W-1:0] mem [DEPTH];

	logic             func_q;
	logic [L-1:0]     bin_q;
	logic [VAL_W-1:0] load_q;
	logic [VAL_W-1:0] req_q;
	logic [NW-1:0]    v_q;
	logic [VAL_W-1:0] cur_q;
	logic [L-1:0]     leaf_idx_q;
	logic             found_q;
	logic [VAL_W-1:0] rdata_q;

	logic             fit;
	logic [NW-1:0]    v_desc;
	logic [NW-1:0]    par;
	logic [VAL_W-1:0] leaf_val;
	logic [VAL_W-1:0] par_val;
	logic [NW-1:0]    raddr;
	logic [NW-1:0]    waddr;
	logic [VAL_W-1:0] wdata;
	logic [NW-1:0]    v_next;
	logic [NW-1:0]    leaf_plus;

	// Shared comparator: the node just read against the request.
	assign fit      = rdata_q >= req_q;
	assign v_desc   = {v_q[NW-2:0], ~fit};
	assign par      = {1'b0, v_q[NW-1:1]};
	assign leaf_val = (func_q == FUNC_REQUEST) ? (rdata_q - req_q) : load_q;
	assign par_val  = (cur_q > rdata_q) ? cur_q : rdata_q;

	// Read address: the next node on the way down, or the sibling on the way up.
	always_comb begin
		unique case (ctl.rd_sel)
			RD_LEFT: raddr = {v_q[NW-2:0], 1'b0};
			RD_DESC: raddr = v_desc[NW-1] ? v_desc : {v_desc[NW-2:0], 1'b0};
			RD_VSIB: raddr = v_q ^ NW'(1);
			RD_PSIB: raddr = par ^ NW'(1);
			default: raddr = NW'(1);
		endcase
	end

	// Write port: clearing, leaf update or refreshed parent maximum.
	always_comb begin
		unique case (ctl.wr_sel)
			WR_LEAF: begin
				waddr = v_q;
				wdata = leaf_val;
			end
			WR_PAR: begin
				waddr = par;
				wdata = par_val;
			end
			default: begin
				waddr = v_q;
				wdata = '0;
			end
		endcase
	end

	// Node register update.
	always_comb begin
		unique case (ctl.v_sel)
			V_INC:   v_next = v_q + NW'(1);
			V_START: v_next = (func_q == FUNC_REQUEST) ? NW'(1) : {1'b1, bin_q};
			V_DESC:  v_next = v_desc;
			V_PAR:   v_next = par;
			default: v_next = v_q;
		endcase
	end

	// Tree memory with registered read data.
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	// Beat payload and running values.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			bin_q  <= L'(cmd_bin);
			load_q <= cmd_load;
			req_q  <= cmd_req;
		end
		if (ctl.wr_en && ctl.wr_sel != WR_ZERO) begin
			cur_q <= wdata;
		end
		if (ctl.leaf_ld) begin
			leaf_idx_q <= v_q[L-1:0];
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			func_q  <= FUNC_LOAD;
			v_q     <= '0;
			found_q <= 1'b0;
		end else begin
			if (in_acc) begin
				func_q <= cmd_func;
			end
			v_q <= v_next;
			if (ctl.found_ld) begin
				found_q <= fit;
			end
		end
	end

	// Status towards the sequencer.
	always_comb begin
		st.clr_end = &v_q;
		st.ok      = (cmd_func == FUNC_REQUEST) ||
		             (({1'b0, cmd_bin} < num_bins) && (32'(cmd_bin) < 32'(MaxBins)));
		st.is_req  = func_q == FUNC_REQUEST;
		st.fit     = fit;
		st.leaf    = v_desc[NW-1];
		st.root    = par == NW'(1);
	end

	// One-based bin number of the chosen leaf.
	assign leaf_plus      = {1'b0, leaf_idx_q} + NW'(1);
	assign res.found      = found_q;
	assign res.bin_number = found_q ? NB_W'(leaf_plus) : '0;

endmodule

/* hw/rtl/first_fit_capacity_allocator_top.sv */
// Top level of the first-fit capacity allocator: channels, register port and result register.
// The allocator keeps a tree of capacity maxima in one single-port-read memory and walks it one
// level per cycle. A request beat walks down the tree to the first bin that fits, then back up
// the tree rewriting the maxima; a request that no bin can hold ends after the root check. A
// load beat writes the leaf, then walks up the tree rewriting the maxima. The next beat can be
// taken in the cycle after the previous one ends; a load outside the bins in use is dropped at
// once. The memory read port is shared by both walks. The last step of a request waits for as
// long as the output register still holds a beat that the sink has not taken. After reset a
// clearing pass writes zero into all 2*2^ceil(log2(MaxBins)) tree nodes, during which no beat
// is taken; register writes are served throughout. A finished result waits in an output
// register while the next command is accepted.
module first_fit_capacity_allocator_top import ffca_pkg::*; #(
	parameter int MaxBins = FFCA_MAX_BINS
) (
	input  logic              clk,
	input  logic              arst_n,
	ffca_cmd_if.sink          cmd,
	ffca_rsp_if.source        rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	ctl_t            ctl;
	stat_t           st;
	res_t            res;
	logic            in_acc;
	logic            out_free;
	logic            fire;
	logic [NB_W-1:0] num_bins_q;
	logic            rsp_valid_q;
	logic            rsp_found_q;
	logic [NB_W-1:0] rsp_bin_q;

	// Register port.
	assign pready = 1'b1;
	assign prdata = (paddr == REG_NUM_BINS) ? DATA_W'(num_bins_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_bins_q <= NUM_BINS_RST;
		end else if (psel && penable && pwrite && pready && paddr == REG_NUM_BINS) begin
			num_bins_q <= pwdata[NB_W-1:0];
		end
	end

	// Channel handshakes.
	assign cmd.ready = ctl.in_rdy;
	assign in_acc    = cmd.valid & cmd.ready;
	assign out_free  = ~rsp_valid_q | rsp.ready;
	assign fire      = ctl.emit & st.is_req & out_free;

	ffca_useq u_useq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_acc   (in_acc),
		.out_free (out_free),
		.st       (st),
		.ctl      (ctl)
	);

	ffca_dpath #(
		.MaxBins (MaxBins)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.in_acc   (in_acc),
		.cmd_func (cmd.func),
		.cmd_bin  (cmd.bin_index),
		.cmd_load (cmd.load_value),
		.cmd_req  (cmd.request_size),
		.num_bins (num_bins_q),
		.st       (st),
		.res      (res)
	);

	// Result register: holds a beat until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_found_q <= res.found;
			rsp_bin_q   <= res.bin_number;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.found      = rsp_found_q;
	assign rsp.bin_number = rsp_bin_q;

	// A command that starts work closes the input for the following cycle.
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && st.ok |=> !cmd.ready)
		else $error("command accepted while the previous one is still in progress");

	// A miss always reports bin number zero.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.found |-> rsp.bin_number == '0)
		else $error("miss reported with a non-zero bin number");

	// No result leaves and no command is taken while the tree is being cleared.
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.wr_en && ctl.wr_sel == WR_ZERO |-> !rsp.valid && !cmd.ready)
		else $error("traffic during the clearing pass");

endmodule

/* dv/tb_first_fit_capacity_allocator_top.sv */
// Self-checking testbench of the first-fit capacity allocator: loads, requests and bin-count settings.
`timescale 1ns / 1ps

module tb_first_fit_capacity_allocator_top;
	import ffca_pkg::*;

	localparam int LEAVES    = FFCA_MAX_BINS;
	localparam int NODES     = 4 * LEAVES;
	localparam int PHASES    = 8;
	localparam int PER_PHASE = 172;
	// A load gives no beat, so after the last result the block may still be rewriting the tree.
	localparam int SETTLE    = 40;

	// Tracks bin capacities in a max tree and holds the allocations still to come back.
	class bin_capacity_tracker;
		logic [VAL_W-1:0] node_max [NODES];
		int unsigned      bin_count;
		res_t             pending_grants [$];
		int               failures;
		int               checked;
		int               grants;
		int               misses;

		function new();
			foreach (node_max[i]) node_max[i] = '0;
			bin_count = NUM_BINS_RST;
			failures  = 0;
			checked   = 0;
			grants    = 0;
			misses    = 0;
		endfunction

		function bit load_taken(int unsigned bin);
			return bin < bin_count && bin < LEAVES;
		endfunction

		// Walks from the root to the leaf of one bin, halving the bin range at each level.
		function int unsigned leaf_node(int unsigned pos);
			int unsigned v;
			int unsigned lo;
			int unsigned hi;
			int unsigned mid;
			v  = 1;
			lo = 0;
			hi = LEAVES - 1;
			while (lo < hi) begin
				mid = (lo + hi) >> 1;
				if (pos <= mid) begin
					v  = 2 * v;
					hi = mid;
				end else begin
					v  = 2 * v + 1;
					lo = mid + 1;
				end
			end
			return v;
		endfunction

		function logic [VAL_W-1:0] capacity(int unsigned bin);
			return node_max[leaf_node(bin)];
		endfunction

		// Writes a leaf and recomputes every maximum on the path to the root.
		function void write_leaf(int unsigned v, logic [VAL_W-1:0] value);
			node_max[v] = value;
			while (v > 1) begin
				v = v >> 1;
				node_max[v] = (node_max[2*v] > node_max[2*v+1]) ? node_max[2*v] : node_max[2*v+1];
			end
		endfunction

		// Applies one accepted command beat and queues the allocation it will return.
		function void note_command(logic func, logic [BIN_W-1:0] bin, logic [VAL_W-1:0] load,
				logic [VAL_W-1:0] size);
			res_t        grant;
			int unsigned v;
			int unsigned lo;
			int unsigned hi;
			int unsigned mid;
			if (func == FUNC_LOAD) begin
				if (load_taken(bin)) write_leaf(leaf_node(bin), load);
				return;
			end
			if (node_max[1] < size) begin
				grant.found      = 1'b0;
				grant.bin_number = '0;
			end else begin
				// Go left whenever the left subtree can hold the request: that gives the first fit.
				v  = 1;
				lo = 0;
				hi = LEAVES - 1;
				while (lo < hi) begin
					mid = (lo + hi) >> 1;
					if (node_max[2*v] >= size) begin
						v  = 2 * v;
						hi = mid;
					end else begin
						v  = 2 * v + 1;
						lo = mid + 1;
					end
				end
				write_leaf(v, node_max[v] - size);
				grant.found      = 1'b1;
				grant.bin_number = NB_W'(lo + 1);
			end
			pending_grants.push_back(grant);
		endfunction

		// Compares one result beat with the oldest allocation waiting.
		function void check_result(logic found, logic [NB_W-1:0] bin_number);
			res_t want;
			if (pending_grants.size() == 0) begin
				$display("%0t: unexpected result beat: found=%0d bin_number=%0d",
					$time, found, bin_number);
				failures++;
				return;
			end
			want = pending_grants.pop_front();
			checked++;
			if (want.found) grants++;
			else misses++;
			if (found !== want.found) begin
				$display("%0t: found mismatch: expected %0d, actual %0d", $time, want.found, found);
				failures++;
			end
			if (bin_number !== want.bin_number) begin
				$display("%0t: bin_number mismatch: expected %0d, actual %0d",
					$time, want.bin_number, bin_number);
				failures++;
			end
		endfunction

		function int outstanding();
			return pending_grants.size();
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	ffca_cmd_if cmd_ch ();
	ffca_rsp_if rsp_ch ();

	bin_capacity_tracker tracker = new();

	int send_idle_pct;
	int recv_stall_pct;
	int stall_burst;
	int items_sent;
	int settings_made;

	first_fit_capacity_allocator_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Clock generation.
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Receiver back-pressure: single-cycle stalls plus the odd long burst.
	always @(negedge clk) begin
		if (stall_burst > 0) begin
			rsp_ch.ready = 1'b0;
			stall_burst--;
		end else if ($urandom_range(0, 99) < recv_stall_pct) begin
			rsp_ch.ready = 1'b0;
			if ($urandom_range(0, 9) == 0) stall_burst = $urandom_range(1, 30);
		end else begin
			rsp_ch.ready = 1'b1;
		end
	end

	// Result beats are checked before the command beat of the same edge is noted.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready)
				tracker.check_result(rsp_ch.found, rsp_ch.bin_number);
			if (cmd_ch.valid && cmd_ch.ready)
				tracker.note_command(cmd_ch.func, cmd_ch.bin_index, cmd_ch.load_value,
					cmd_ch.request_size);
		end
	end

	// Offers one command beat, with random idle cycles first, and returns once it is taken.
	task automatic push_cmd(input logic func, input logic [BIN_W-1:0] bin,
			input logic [VAL_W-1:0] load, input logic [VAL_W-1:0] size);
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < send_idle_pct) gap++;
		if (send_idle_pct > 0 && $urandom_range(0, 9) == 0) gap += $urandom_range(1, 30);
		if (gap > 0) begin
			cmd_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_ch.valid        = 1'b1;
		cmd_ch.func         = func;
		cmd_ch.bin_index    = bin;
		cmd_ch.load_value   = load;
		cmd_ch.request_size = size;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic load_bin(input int unsigned bin, input logic [VAL_W-1:0] value);
		push_cmd(FUNC_LOAD, BIN_W'(bin), value, VAL_W'($urandom));
	endtask

	task automatic ask_for(input logic [VAL_W-1:0] size);
		push_cmd(FUNC_REQUEST, BIN_W'($urandom), VAL_W'($urandom), size);
	endtask

	task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = addr;
		pwdata  = data;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic apb_read(input logic [ADDR_W-1:0] addr, output logic [DATA_W-1:0] data);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = addr;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		data = prdata;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	task automatic check_bin_count(input logic [NB_W-1:0] want);
		logic [DATA_W-1:0] got;
		apb_read(REG_NUM_BINS, got);
		if (got !== DATA_W'(want)) begin
			$display("%0t: num_bins read-back mismatch: expected %0d, actual %0d",
				$time, want, got);
			tracker.failures++;
		end
	endtask

	// Lets every result come back and the last tree update finish.
	task automatic drain();
		cmd_ch.valid = 1'b0;
		while (tracker.outstanding() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic set_bin_count(input logic [NB_W-1:0] value);
		drain();
		apb_write(REG_NUM_BINS, DATA_W'(value));
		check_bin_count(value);
		tracker.bin_count = value;
		settings_made++;
	endtask

	// One random beat: a load, sometimes outside the bins in use, or a request.
	task automatic random_item();
		int unsigned      in_use;
		int unsigned      bin;
		int unsigned      pick;
		logic [VAL_W-1:0] value;
		in_use = (tracker.bin_count < LEAVES) ? tracker.bin_count : LEAVES;
		if ($urandom_range(0, 99) < 40) begin
			if (in_use > 0 && $urandom_range(0, 9) != 0) bin = $urandom_range(0, in_use - 1);
			else bin = $urandom_range(0, LEAVES - 1);
			pick = $urandom_range(0, 9);
			if (pick < 4) value = $urandom_range(0, 1000);
			else if (pick < 7) value = $urandom_range(1, 1 << 20);
			else if (pick < 9) value = VAL_W'($urandom);
			else value = '0;
			load_bin(bin, value);
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				// Aim at the capacity of a bin in use, so that fits are common.
				if (in_use > 0) bin = $urandom_range(0, in_use - 1);
				else bin = $urandom_range(0, LEAVES - 1);
				value = tracker.capacity(bin);
				value = (value == 0) ? VAL_W'(1) : VAL_W'($urandom_range(1, value));
			end else if (pick < 70) begin
				value = $urandom_range(1, 1000);
			end else if (pick < 85) begin
				value = VAL_W'($urandom);
			end else if (pick < 92) begin
				value = tracker.node_max[1];
			end else if (pick < 97) begin
				value = tracker.node_max[1] + 1'b1;
			end else begin
				value = '0;
			end
			ask_for(value);
		end
	endtask

	// Main sequence.
	initial begin
		logic [NB_W-1:0] bin_settings [PHASES];

		arst_n              = 1'b0;
		psel                = 1'b0;
		penable             = 1'b0;
		pwrite              = 1'b0;
		paddr               = '0;
		pwdata              = '0;
		cmd_ch.valid        = 1'b0;
		cmd_ch.func         = FUNC_LOAD;
		cmd_ch.bin_index    = '0;
		cmd_ch.load_value   = '0;
		cmd_ch.request_size = '0;
		rsp_ch.ready        = 1'b0;
		send_idle_pct       = 0;
		recv_stall_pct      = 0;
		stall_burst         = 0;
		items_sent          = 0;
		settings_made       = 0;
		bin_settings        = '{11'd16, 11'd1024, 11'd1, 11'd0, 11'd2047, 11'd300, 11'd2,
			NB_W'($urandom_range(1, LEAVES))};

		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		check_bin_count(NUM_BINS_RST);

		// Directed beats on the cleared tree: misses, zero requests, extreme bins and values.
		ask_for(30'd1);
		ask_for(30'd0);
		load_bin(0, 30'h3FFF_FFFF);
		load_bin(LEAVES - 1, 30'h3FFF_FFFF);
		load_bin(512, 30'd100);
		load_bin(511, 30'd50);
		ask_for(30'h3FFF_FFFF);
		ask_for(30'h3FFF_FFFF);
		ask_for(30'd60);
		ask_for(30'd50);
		ask_for(30'd41);
		ask_for(30'd40);
		ask_for(30'd0);
		load_bin(10'h155, 30'h2AAA_AAAA);
		load_bin(10'h2AA, 30'h1555_5555);
		ask_for(30'h2AAA_AAAA);
		ask_for(30'h1555_5555);
		ask_for(30'd1);
		load_bin(LEAVES - 1, 30'd0);
		ask_for(30'd1);

		// Random phases, each setting a new bin count and one of four handshake pressures.
		for (int p = 0; p < PHASES; p++) begin
			set_bin_count(bin_settings[p]);
			case (p % 4)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 58;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 58;
				end
				default: begin
					send_idle_pct  = 22;
					recv_stall_pct = 22;
				end
			endcase
			for (int i = 0; i < PER_PHASE; i++) random_item();
		end

		drain();
		$display("Sent %0d command beats over %0d bin-count settings (0, 1, 1024 and 2047 among them).",
			items_sent, settings_made + 1);
		$display("Checked %0d result beats: %0d allocations granted, %0d found no bin.",
			tracker.checked, tracker.grants, tracker.misses);
		if (tracker.failures == 0 && tracker.outstanding() == 0)
			$display("** first_fit_capacity_allocator_top: PASSED **");
		else
			$display("** first_fit_capacity_allocator_top: FAILED **");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#6_000_000;
		$display("Timeout with %0d results outstanding.", tracker.outstanding());
		$display("** first_fit_capacity_allocator_top: FAILED **");
		$finish;
	end

endmodule
